[hdl/ihsp_pkg.sv]
// Shared types, codes and helpers for the image header size parser.
package ihsp_pkg;

    // Image layout codes held in the format register
    localparam logic [1:0] FMT_PNG = 2'd0;
    localparam logic [1:0] FMT_BMP = 2'd1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_NO_SIZE = 2'd2;

    // Register map (word index)
    localparam logic REG_FORMAT = 1'b0;

    // Header offsets and short-file limits (byte counts)
    localparam logic [4:0] PNG_FIRST = 5'd16;
    localparam logic [4:0] PNG_LAST  = 5'd23;
    localparam logic [4:0] BMP_FIRST = 5'd18;
    localparam logic [4:0] BMP_LAST  = 5'd25;
    localparam logic [4:0] POS_MAX   = 5'd31;

    // JPEG marker bytes
    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_EOI  = 8'hD9;

    // JPEG walk phase
    typedef enum logic [3:0] {
        PH_SIG0 = 4'd0,
        PH_SIG1 = 4'd1,
        PH_MARK = 4'd2,
        PH_LENH = 4'd3,
        PH_LENL = 4'd4,
        PH_SKIP = 4'd5,
        PH_PREC = 4'd6,
        PH_HH   = 4'd7,
        PH_HL   = 4'd8,
        PH_WH   = 4'd9,
        PH_WL   = 4'd10,
        PH_STOP = 4'd11,
        PH_BAD  = 4'd12
    } t_phase;

    // One input transaction
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       eof;
    } t_item;

    // One result, packed as it leaves on the output bus (width lowest)
    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] height;
        logic [30:0] width;
    } t_result;

    // Start-of-frame markers: C0-C3, C5-C7, C9-CB, CD-CF
    function automatic logic is_sof(input logic [7:0] m);
        logic r;
        r = (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hC7) ||
            (m >= 8'hC9 && m <= 8'hCB) || (m >= 8'hCD && m <= 8'hCF);
        return r;
    endfunction

endpackage

[hdl/ihsp_apb_regs.sv]
// Configuration register file: image format register on an APB-style port.
module ihsp_apb_regs
    import ihsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    output logic [1:0]  o_format
);

    logic [1:0] r_format;
    logic       wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_FORMAT);

    // Format register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_PNG;
        end else if (wr_en) begin
            r_format <= i_pwdata[1:0];
        end
    end

    // Read mux
    always_comb begin
        o_prdata = 32'd0;
        if (i_paddr[2] == REG_FORMAT) begin
            o_prdata = {30'd0, r_format};
        end
    end

    assign o_format = r_format;

endmodule

[hdl/ihsp_in_stage.sv]
// Input register stage: captures one byte transaction from the stream slave.
module ihsp_in_stage
    import ihsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_take,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held item is consumed this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hdl/ihsp_parser.sv]
// Per-file parse state, one-byte update logic and the result register.
module ihsp_parser
    import ihsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic [1:0] i_format,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_result
);

    // File state
    t_phase      r_phase;
    logic [4:0]  r_pos;
    logic [15:0] r_shift;
    logic [31:0] r_width;
    logic [31:0] r_height;
    logic [15:0] r_skip;

    // State after this byte, before the end-of-file clear
    t_phase      upd_phase;
    logic [4:0]  upd_pos;
    logic [15:0] upd_shift;
    logic [31:0] upd_width;
    logic [31:0] upd_height;
    logic [15:0] upd_skip;

    logic        step;
    logic        finish;
    logic [7:0]  b;
    logic [4:0]  k_png;
    logic [4:0]  k_bmp;
    logic [1:0]  lane;
    logic [15:0] seg_len;
    logic [15:0] skip_dec;

    logic [31:0] res_w;
    logic [31:0] res_h;
    logic [31:0] bmp_h;
    logic [1:0]  res_st;

    logic    r_res_valid;
    t_result r_result;

    // Item consumed unless it is a file end and the result slot stays full
    assign o_take = i_valid && (!i_item.eof || !r_res_valid || i_res_ready);
    assign step   = o_take;
    assign finish = step && i_item.eof;
    assign b      = i_item.data;

    assign k_png    = r_pos - PNG_FIRST;
    assign k_bmp    = r_pos - BMP_FIRST;
    assign seg_len  = {r_shift[7:0], b};
    assign skip_dec = r_skip - 16'd1;

    // One-byte update
    always_comb begin
        upd_phase  = r_phase;
        upd_pos    = r_pos;
        upd_shift  = r_shift;
        upd_width  = r_width;
        upd_height = r_height;
        upd_skip   = r_skip;
        lane       = 2'd0;
        if (step && i_item.byte_valid) begin
            if (i_format == FMT_PNG) begin
                // big-endian lanes at offset 16
                if (r_pos >= PNG_FIRST && r_pos <= PNG_LAST) begin
                    lane = 2'd3 - k_png[1:0];
                    if (!k_png[2]) begin
                        upd_width[{lane, 3'b000} +: 8] = r_width[{lane, 3'b000} +: 8] | b;
                    end else begin
                        upd_height[{lane, 3'b000} +: 8] = r_height[{lane, 3'b000} +: 8] | b;
                    end
                end
            end else if (i_format == FMT_BMP) begin
                // little-endian lanes at offset 18
                if (r_pos >= BMP_FIRST && r_pos <= BMP_LAST) begin
                    lane = k_bmp[1:0];
                    if (!k_bmp[2]) begin
                        upd_width[{lane, 3'b000} +: 8] = r_width[{lane, 3'b000} +: 8] | b;
                    end else begin
                        upd_height[{lane, 3'b000} +: 8] = r_height[{lane, 3'b000} +: 8] | b;
                    end
                end
            end else begin
                // JPEG marker walk
                unique case (r_phase)
                    PH_SIG0: upd_phase = (b == MK_FILL) ? PH_SIG1 : PH_BAD;
                    PH_SIG1: upd_phase = (b == MK_SOI) ? PH_MARK : PH_BAD;
                    PH_MARK: begin
                        if (b != MK_FILL && b != MK_SOI && b != MK_EOI) begin
                            upd_shift = {b, 8'd0};
                            upd_phase = PH_LENH;
                        end
                    end
                    PH_LENH: begin
                        upd_shift = {r_shift[15:8], b};
                        upd_phase = PH_LENL;
                    end
                    PH_LENL: begin
                        if (seg_len < 16'd2) begin
                            upd_phase = PH_STOP;
                        end else if (is_sof(r_shift[15:8])) begin
                            upd_phase = PH_PREC;
                        end else begin
                            upd_skip  = seg_len - 16'd2;
                            upd_phase = (seg_len == 16'd2) ? PH_MARK : PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        upd_skip = skip_dec;
                        if (skip_dec == 16'd0) begin
                            upd_phase = PH_MARK;
                        end
                    end
                    PH_PREC: upd_phase = PH_HH;
                    PH_HH: begin
                        upd_shift = {8'd0, b};
                        upd_phase = PH_HL;
                    end
                    PH_HL: begin
                        upd_height = {16'd0, r_shift[7:0], b};
                        upd_phase  = PH_WH;
                    end
                    PH_WH: begin
                        upd_shift = {8'd0, b};
                        upd_phase = PH_WL;
                    end
                    PH_WL: begin
                        upd_width = {16'd0, r_shift[7:0], b};
                        upd_phase = PH_STOP;
                    end
                    default: upd_phase = r_phase;
                endcase
            end
            if (r_pos < POS_MAX) begin
                upd_pos = r_pos + 5'd1;
            end
        end
    end

    // Result from the updated state
    assign bmp_h = (upd_pos >= 5'd26) ? upd_height : 32'd0;

    always_comb begin
        res_w  = 32'd0;
        res_h  = 32'd0;
        res_st = ST_OK;
        if (i_format == FMT_PNG) begin
            res_w = {(upd_pos >= 5'd18) ? upd_width[31:16] : 16'd0,
                     (upd_pos >= 5'd20) ? upd_width[15:0]  : 16'd0};
            res_h = {(upd_pos >= 5'd22) ? upd_height[31:16] : 16'd0,
                     (upd_pos >= 5'd24) ? upd_height[15:0]  : 16'd0};
        end else if (i_format == FMT_BMP) begin
            res_w = (upd_pos >= 5'd22) ? upd_width : 32'd0;
            res_h = bmp_h[31] ? (~bmp_h + 32'd1) : bmp_h;
        end else if (upd_phase == PH_SIG0 || upd_phase == PH_SIG1 ||
                     upd_phase == PH_BAD) begin
            res_st = ST_BAD_SIG;
        end else begin
            res_w = upd_width;
            res_h = upd_height;
        end
        if (res_st == ST_OK && (res_w == 32'd0 || res_h == 32'd0 ||
                                res_w[31] || res_h[31])) begin
            res_st = ST_NO_SIZE;
        end
        if (res_st != ST_OK) begin
            res_w = 32'd0;
            res_h = 32'd0;
        end
    end

    // File state registers; a file end returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_phase  <= PH_SIG0;
            r_pos    <= 5'd0;
            r_shift  <= 16'd0;
            r_width  <= 32'd0;
            r_height <= 32'd0;
            r_skip   <= 16'd0;
        end else begin
            r_phase  <= upd_phase;
            r_pos    <= upd_pos;
            r_shift  <= upd_shift;
            r_width  <= upd_width;
            r_height <= upd_height;
            r_skip   <= upd_skip;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (finish) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_result.status <= res_st;
            r_result.height <= res_h[30:0];
            r_result.width  <= res_w[30:0];
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

`ifndef ASSERT_OFF
    // A failed result carries no size
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_result.status != ST_OK |->
            r_result.width == 31'd0 && r_result.height == 31'd0)
        else $error("failed result with nonzero size");

    // Skip phase always has bytes left to skip
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_skip != 16'd0)
        else $error("skip phase with empty count");

    // File end clears the per-file state
    a_clear_after_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_pos == 5'd0 && r_phase == PH_SIG0 && r_skip == 16'd0)
        else $error("file state not cleared after file end");

    // A file end never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> !r_res_valid || i_res_ready)
        else $error("result overwritten while stalled");

    // Byte count saturates instead of wrapping
    a_pos_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == POS_MAX && step && !i_item.eof |=> r_pos == POS_MAX)
        else $error("byte count wrapped");
`endif

endmodule

[hdl/image_header_size_parser.sv]
// Top level of the image header size parser.
//
// Streams the bytes of one image file in on the s_axis slave, one byte per
// transaction: tdata is the byte, tuser is 1 when tdata carries a byte (0 for
// an empty end marker) and tlast marks the file's final transaction. One
// result per file leaves on the m_axis master as width, height and status
// (0 ok, 1 bad JPEG signature, 2 size missing or not positive).
// The format register (APB, address 0: 0 PNG, 1 BMP, 2 or 3 JPEG) selects
// the header layout; write it only between files.
// Throughput is one byte per cycle unless a tlast transaction waits for the
// result slot: each byte passes from the input register through a single
// update of the parse state. An accepted tlast transaction goes to the input
// register, then the result register loads and raises tvalid on m_axis.
// The result register holds one result; while the receiver stalls, non-final
// bytes keep flowing and only the next tlast transaction waits for the slot.
// Synchronous reset clears the format to PNG, the parse state, and both
// handshake stages; no result is pending after reset.
module image_header_size_parser
    import ihsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Stream slave
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_file
    // Stream master
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [30:0] image_width, [61:31] image_height,
                                        // [63:62] status
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0] format;
    t_item      in_item;
    t_item      held_item;
    logic       held_valid;
    logic       take;
    t_result    result;

    assign in_item.data       = s_axis_tdata;
    assign in_item.byte_valid = s_axis_tuser;
    assign in_item.eof        = s_axis_tlast;

    ihsp_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_format  (format)
    );

    ihsp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (take),
        .o_item  (held_item)
    );

    ihsp_parser u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_format    (format),
        .i_valid     (held_valid),
        .i_item      (held_item),
        .o_take      (take),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = result;

endmodule

[tb/tb_image_header_size_parser.sv]
// Self-checking testbench for the image header size parser (PNG, BMP and JPEG layouts).
module tb_image_header_size_parser
    import ihsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // JPEG layout codes (the upper code is unused and behaves as JPEG)
    localparam logic [1:0] FMT_JPEG     = 2'd2;
    localparam logic [1:0] FMT_JPEG_ALT = 2'd3;
    localparam logic [2:0] FORMAT_ADDR  = {REG_FORMAT, 2'b00};
    localparam int         ITEM_TARGET  = 1150;

    // DUT inputs, all known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;

    // DUT outputs
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [63:0] m_axis_tdata;
    logic [31:0] prdata;
    logic        pready;

    image_header_size_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Parser state as predicted by the testbench
    logic [1:0]  fmt_reg;
    t_phase      jpeg_phase;
    logic [4:0]  pos;
    logic [31:0] shreg;
    logic [31:0] width_acc;
    logic [31:0] height_acc;
    logic [15:0] skip_left;

    t_result     expected_sizes[$];
    logic [7:0]  file_bytes[$];

    int items_sent     = 0;
    int files_sent     = 0;
    int sizes_checked  = 0;
    int mismatch_count = 0;
    int burst_left     = 0;
    int rx_cycle       = 0;
    int rx_mode        = 0;

    task automatic clear_parse_state();
        jpeg_phase = PH_SIG0;
        pos        = '0;
        shreg      = '0;
        width_acc  = '0;
        height_acc = '0;
        skip_left  = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
    endtask

    // C0-CF except C4, C8 and CC start a frame
    function automatic bit sof_marker(input logic [7:0] m);
        return (m[7:4] == 4'hC) && (m[1:0] != 2'b00 || m[3:2] == 2'b00);
    endfunction

    // Advance the predicted parser by one accepted transaction
    task automatic track_item(input logic [7:0] d, input logic bv, input logic eof);
        int          k;
        logic [15:0] seg_len;
        logic [31:0] w;
        logic [31:0] h;
        logic [1:0]  st;
        t_result     r;
        if (bv) begin
            if (fmt_reg == FMT_PNG && pos >= PNG_FIRST && pos <= PNG_LAST) begin
                // big-endian width then height
                k = int'(pos) - int'(PNG_FIRST);
                if (k < 4) width_acc  |= 32'(d) << ((3 - k % 4) * 8);
                else       height_acc |= 32'(d) << ((3 - k % 4) * 8);
            end else if (fmt_reg == FMT_BMP && pos >= BMP_FIRST && pos <= BMP_LAST) begin
                // little-endian width then height
                k = int'(pos) - int'(BMP_FIRST);
                if (k < 4) width_acc  |= 32'(d) << ((k % 4) * 8);
                else       height_acc |= 32'(d) << ((k % 4) * 8);
            end else if (fmt_reg[1]) begin
                // JPEG marker walk
                case (jpeg_phase)
                    PH_SIG0: jpeg_phase = (d == MK_FILL) ? PH_SIG1 : PH_BAD;
                    PH_SIG1: jpeg_phase = (d == MK_SOI) ? PH_MARK : PH_BAD;
                    PH_MARK: begin
                        if (d != MK_FILL && d != MK_SOI && d != MK_EOI) begin
                            shreg      = {16'h0, d, 8'h00};
                            jpeg_phase = PH_LENH;
                        end
                    end
                    PH_LENH: begin
                        shreg      = {16'h0, shreg[15:8], d};
                        jpeg_phase = PH_LENL;
                    end
                    PH_LENL: begin
                        seg_len = {shreg[7:0], d};
                        if (seg_len < 16'd2) begin
                            jpeg_phase = PH_STOP;
                        end else if (sof_marker(shreg[15:8])) begin
                            jpeg_phase = PH_PREC;
                        end else begin
                            skip_left  = seg_len - 16'd2;
                            jpeg_phase = (skip_left != 16'd0) ? PH_SKIP : PH_MARK;
                        end
                    end
                    PH_SKIP: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0) jpeg_phase = PH_MARK;
                    end
                    PH_PREC: jpeg_phase = PH_HH;
                    PH_HH: begin
                        shreg      = {24'h0, d};
                        jpeg_phase = PH_HL;
                    end
                    PH_HL: begin
                        height_acc = {16'h0, shreg[7:0], d};
                        jpeg_phase = PH_WH;
                    end
                    PH_WH: begin
                        shreg      = {24'h0, d};
                        jpeg_phase = PH_WL;
                    end
                    PH_WL: begin
                        width_acc  = {16'h0, shreg[7:0], d};
                        jpeg_phase = PH_STOP;
                    end
                    default: ;
                endcase
            end
            if (pos != POS_MAX) pos = pos + 5'd1;
        end
        if (eof) begin
            w  = '0;
            h  = '0;
            st = ST_OK;
            if (fmt_reg == FMT_PNG) begin
                // a 16-bit half only counts when both of its bytes arrived
                w = {(pos >= PNG_FIRST + 5'd2) ? width_acc[31:16] : 16'h0,
                     (pos >= PNG_FIRST + 5'd4) ? width_acc[15:0]  : 16'h0};
                h = {(pos >= PNG_FIRST + 5'd6) ? height_acc[31:16] : 16'h0,
                     (pos >= PNG_FIRST + 5'd8) ? height_acc[15:0]  : 16'h0};
            end else if (fmt_reg == FMT_BMP) begin
                w = (pos >= BMP_FIRST + 5'd4) ? width_acc  : 32'h0;
                h = (pos >= BMP_FIRST + 5'd8) ? height_acc : 32'h0;
                if (h[31]) h = ~h + 32'd1;
            end else if (jpeg_phase == PH_SIG0 || jpeg_phase == PH_SIG1 ||
                         jpeg_phase == PH_BAD) begin
                st = ST_BAD_SIG;
            end else begin
                w = width_acc;
                h = height_acc;
            end
            if (st == ST_OK && (w == 32'h0 || h == 32'h0 || w[31] || h[31]))
                st = ST_NO_SIZE;
            if (st != ST_OK) begin
                w = '0;
                h = '0;
            end
            r.width  = w[30:0];
            r.height = h[30:0];
            r.status = st;
            expected_sizes.push_back(r);
            clear_parse_state();
        end
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (expected_sizes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] result with nothing expected: 0x%0h",
                             $realtime, m_axis_tdata);
            end else begin
                want = expected_sizes.pop_front();
                sizes_checked++;
                if (got.width != want.width)
                    report_mismatch("image_width", 32'(want.width), 32'(got.width));
                if (got.height != want.height)
                    report_mismatch("image_height", 32'(want.height), 32'(got.height));
                if (got.status != want.status)
                    report_mismatch("status", 32'(want.status), 32'(got.status));
            end
        end
    end

    // Receiver: ready follows one of four stall patterns, drawn at random
    always @(negedge i_clk) begin
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       m_axis_tready = 1'b1;
            1:       m_axis_tready = 1'($urandom_range(0, 1));
            2:       m_axis_tready = (rx_cycle % 5 != 0);
            default: m_axis_tready = (rx_cycle % 32 < 12);
        endcase
        rx_cycle++;
    end

    // Send one input transaction; the sender works in bursts with gaps between
    task automatic send_byte(input logic [7:0] d, input logic bv, input logic eof);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        s_axis_tuser  = bv;
        s_axis_tlast  = eof;
        do @(posedge i_clk); while (!s_axis_tready);
        if (bv || eof) items_sent++;
        track_item(d, bv, eof);
    endtask

    // Stream file_bytes as one file, optionally closed by an empty end marker
    task automatic send_file(input bit empty_end, input int noise_pct);
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_byte(file_bytes[i], 1'b1, !empty_end && i == n - 1);
        end
        if (empty_end || n == 0)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        files_sent++;
    endtask

    // Drop valid and let every pending result drain before touching the register
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        burst_left    = 0;
        while (expected_sizes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write the format register between files and read it back
    task automatic set_format(input logic [1:0] f);
        logic [31:0] rd;
        wait_idle();
        apb_access(1'b1, FORMAT_ADDR, {30'h0, f}, rd);
        fmt_reg = f;
        apb_access(1'b0, FORMAT_ADDR, 32'h0, rd);
        if (rd[1:0] != f) report_mismatch("format readback", 32'(f), rd);
    endtask

    task automatic push_rand(input int n);
        repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic push_word(input logic [31:0] v, input bit big_endian);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(big_endian ? v[8*(3-i) +: 8] : v[8*i +: 8]);
    endtask

    // Header file: random lead-in, width, height, then padded or cut to len
    task automatic build_header(input logic [1:0] f, input logic [31:0] w,
                                input logic [31:0] h, input int len);
        file_bytes.delete();
        push_rand((f == FMT_PNG) ? int'(PNG_FIRST) : int'(BMP_FIRST));
        push_word(w, f == FMT_PNG);
        push_word(h, f == FMT_PNG);
        if (len > file_bytes.size()) push_rand(len - file_bytes.size());
        while (file_bytes.size() > len) void'(file_bytes.pop_back());
    endtask

    function automatic logic [7:0] pick_marker(input bit want_sof);
        logic [7:0] m;
        do m = 8'($urandom_range(0, 255));
        while (m == MK_FILL || m == MK_SOI || m == MK_EOI || sof_marker(m) != want_sof);
        return m;
    endfunction

    // JPEG file: signature, some filler and skipped segments, then a frame
    // header or a segment with a length below two
    task automatic build_jpeg(input logic [15:0] h, input logic [15:0] w,
                              input int segs, input bit short_len);
        int         len;
        logic [7:0] m;
        file_bytes.delete();
        file_bytes.push_back(MK_FILL);
        file_bytes.push_back(MK_SOI);
        repeat (segs) begin
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 3)) file_bytes.push_back(MK_FILL);
                1: file_bytes.push_back($urandom_range(0, 1) ? MK_SOI : MK_EOI);
                default: begin
                    m   = pick_marker(1'b0);
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300)
                                                       : $urandom_range(2, 9);
                    file_bytes.push_back(m);
                    file_bytes.push_back(8'(len >> 8));
                    file_bytes.push_back(8'(len));
                    push_rand(len - 2);
                end
            endcase
        end
        if (short_len) begin
            file_bytes.push_back(pick_marker(1'($urandom_range(0, 1))));
            file_bytes.push_back(8'h00);
            file_bytes.push_back(8'($urandom_range(0, 1)));
        end else begin
            file_bytes.push_back(pick_marker(1'b1));
            file_bytes.push_back(8'h00);
            file_bytes.push_back(8'h11);
            file_bytes.push_back(8'h08);
            file_bytes.push_back(h[15:8]);
            file_bytes.push_back(h[7:0]);
            file_bytes.push_back(w[15:8]);
            file_bytes.push_back(w[7:0]);
        end
        push_rand($urandom_range(0, 3));
    endtask

    function automatic logic [31:0] rand_dim();
        case ($urandom_range(0, 11))
            0:       return 32'h0;
            1:       return 32'h8000_0000 | 32'($urandom);
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            4:       return -32'($urandom_range(1, 5000));
            5, 6:    return 32'($urandom);
            default: return 32'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [15:0] rand_dim16();
        case ($urandom_range(0, 9))
            0:       return 16'h0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic test_png_headers();
        set_format(FMT_PNG);
        build_header(FMT_PNG, 32'd640, 32'd480, 24);              send_file(1'b0, 0);
        build_header(FMT_PNG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 30);  send_file(1'b1, 20);
        build_header(FMT_PNG, 32'h8000_0001, 32'd5, 24);          send_file(1'b0, 0);
        build_header(FMT_PNG, 32'd5, 32'd0, 24);                  send_file(1'b0, 0);
        // file ends after the upper half of the height
        build_header(FMT_PNG, 32'd5, 32'h0001_0000, 22);          send_file(1'b0, 0);
        build_header(FMT_PNG, 32'h0002_0003, 32'd9, 19);          send_file(1'b0, 0);
    endtask

    task automatic test_bmp_headers();
        set_format(FMT_BMP);
        build_header(FMT_BMP, 32'd800, 32'd600, 26);              send_file(1'b0, 0);
        // bottom-up height, long file past the position counter limit
        build_header(FMT_BMP, 32'd3, 32'hFFFF_FF00, 40);          send_file(1'b0, 10);
        build_header(FMT_BMP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 26);  send_file(1'b1, 0);
        build_header(FMT_BMP, 32'd3, 32'h8000_0000, 26);          send_file(1'b0, 0);
        build_header(FMT_BMP, 32'd12, 32'd34, 25);                send_file(1'b0, 0);
    endtask

    task automatic test_jpeg_walk();
        set_format(FMT_JPEG);
        // bad signature, one-byte file, empty file
        file_bytes = {8'hFF, 8'h00, 8'hC0, 8'h00};                send_file(1'b0, 0);
        file_bytes = {8'hFF};                                     send_file(1'b0, 0);
        file_bytes.delete();                                      send_file(1'b1, 0);
        // fill bytes, bare SOI/EOI, empty and short segments, progressive frame
        file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'hD9, 8'hD8, 8'hE0, 8'h00, 8'h02,
                      8'hFF, 8'hDB, 8'h00, 8'h04, 8'hAA, 8'h55, 8'hC2, 8'h00, 8'h11,
                      8'h08, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h03};
        send_file(1'b0, 10);
        // segment length below two stops the walk
        file_bytes = {8'hFF, 8'hD8, 8'hE1, 8'h00, 8'h01, 8'hC0, 8'h00, 8'h11};
        send_file(1'b0, 0);
        // file ends inside the frame header
        file_bytes = {8'hFF, 8'hD8, 8'hC0, 8'h00, 8'h11, 8'h08, 8'h01};
        send_file(1'b0, 0);
        build_jpeg(16'd1080, 16'd1920, 3, 1'b0);                  send_file(1'b1, 0);
    endtask

    task automatic test_reserved_format();
        set_format(FMT_JPEG_ALT);
        build_jpeg(16'd480, 16'd640, 2, 1'b0);                    send_file(1'b0, 0);
        file_bytes = {8'hFE, 8'hD8};                              send_file(1'b0, 0);
    endtask

    task automatic random_file(input logic [1:0] f);
        int pick;
        pick = $urandom_range(0, 19);
        if (!f[1]) begin
            if (pick < 3)
                build_header(f, rand_dim(), rand_dim(), $urandom_range(0, 25));
            else
                build_header(f, rand_dim(), rand_dim(), $urandom_range(24, 34));
        end else begin
            if (pick < 13) begin
                build_jpeg(rand_dim16(), rand_dim16(), $urandom_range(0, 4), 1'b0);
            end else if (pick < 15) begin
                build_jpeg(rand_dim16(), rand_dim16(), $urandom_range(0, 3), 1'b1);
            end else if (pick < 17) begin
                build_jpeg(rand_dim16(), rand_dim16(), $urandom_range(0, 2), 1'b0);
                file_bytes[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
            end else begin
                // random bytes, mostly after a valid signature
                file_bytes.delete();
                if (pick != 19) begin
                    file_bytes.push_back(MK_FILL);
                    file_bytes.push_back(MK_SOI);
                end
                push_rand($urandom_range(0, 30));
            end
            // some files are cut short at a random point
            if ($urandom_range(0, 6) == 0)
                while (file_bytes.size() > 0 &&
                       file_bytes.size() > $urandom_range(0, 12))
                    void'(file_bytes.pop_back());
        end
        send_file($urandom_range(0, 7) == 0, ($urandom_range(0, 3) == 0) ? 10 : 0);
    endtask

    task automatic test_random_files();
        while (items_sent < ITEM_TARGET) begin
            set_format(2'($urandom_range(0, 3)));
            repeat ($urandom_range(3, 8)) random_file(fmt_reg);
        end
    endtask

    // Main sequence
    initial begin
        fmt_reg = FMT_PNG;
        clear_parse_state();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_png_headers();
        test_bmp_headers();
        test_jpeg_walk();
        test_reserved_format();
        test_random_files();

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d size results from %0d files (%0d byte transactions)",
                 sizes_checked, files_sent, items_sent);
        $display("Covered PNG, BMP and JPEG layouts plus the unused code; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_sizes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_sizes.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/ihsp_pkg.sv
hdl/ihsp_apb_regs.sv
hdl/ihsp_in_stage.sv
hdl/ihsp_parser.sv
hdl/image_header_size_parser.sv
tb/tb_image_header_size_parser.sv
